// ===== src/dpr_pkg.sv =====
// Shared types, constants and helpers of the dense PageRank block.
package dpr_pkg;

  localparam int unsigned NODE_W   = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ITER_W   = 8;
  localparam int unsigned DAMP_W   = 16;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned DEG_W    = 7;
  localparam int unsigned RANK_W   = 48;
  localparam int unsigned ADDR_W   = 2 * NODE_W;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W    = 16;

  localparam logic [CNT_W-1:0]  MAX_NODES_C = 7'd64;
  localparam logic [RANK_W-1:0] RMAX        = {RANK_W{1'b1}};
  localparam logic [RANK_W-1:0] RANK_ONE    = 48'd1 << 24;

  localparam logic [1:0] MODE_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_DEGREE = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [NODE_W-1:0]   source_node;
    logic [NODE_W-1:0]   target_node;
    logic [WEIGHT_W-1:0] link_weight;
    logic [DEG_W-1:0]    out_degree;
  } in_word_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [RANK_W-1:0] rank_plain;
    logic [RANK_W-1:0] rank_unscaled;
    logic [RANK_W-1:0] rank_weighted_unscaled;
    logic [RANK_W-1:0] rank_weighted;
    logic              last;
  } out_word_t;

  typedef enum logic [3:0] {
    CMD_IDLE, CMD_CLEAR, CMD_LOAD, CMD_TDIV, CMD_TSTORE, CMD_INIT, CMD_ACC_CLR,
    CMD_READ, CMD_MUL_LO, CMD_MUL_HI, CMD_MUL_CMB, CMD_DIV, CMD_ACC, CMD_WRITE,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [2:0] {
    MOP_R3, MOP_R4, MOP_A1, MOP_A2, MOP_A3, MOP_A4
  } mop_e;

  typedef struct packed {
    cmd_e              op;
    mop_e              mop;
    logic [NODE_W-1:0] row;
    logic [NODE_W-1:0] col;
    logic [ADDR_W-1:0] clr_addr;
    logic [CNT_W-1:0]  count;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic div_busy;
    logic out_free;
  } stat_t;

  function automatic logic [RANK_W-1:0] sat_add(input logic [RANK_W-1:0] a,
                                                input logic [RANK_W-1:0] b);
    logic [RANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RANK_W] ? RMAX : s[RANK_W-1:0];
  endfunction

endpackage

// ===== src/dpr_div.sv =====
// Radix-2 restoring divider: rank value by a small count, one bit per cycle.
module dpr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dpr_pkg::RANK_W-1:0]   dividend_i,
  input  logic [dpr_pkg::DEG_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [dpr_pkg::RANK_W-1:0]   quotient_o
);

  logic [dpr_pkg::RANK_W-1:0]    quo_q;
  logic [dpr_pkg::DEG_W-1:0]     rem_q;
  logic [dpr_pkg::DEG_W-1:0]     dvs_q;
  logic [dpr_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          busy_q;
  logic [dpr_pkg::DEG_W:0]       part;
  logic [dpr_pkg::DEG_W:0]       diff;
  logic                          ge;

  assign part = {rem_q, quo_q[dpr_pkg::RANK_W-1]};
  assign ge   = part >= {1'b0, dvs_q};
  assign diff = ge ? (part - {1'b0, dvs_q}) : part;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= dpr_pkg::DIV_CNT_W'(dpr_pkg::RANK_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[dpr_pkg::RANK_W-2:0], ge};
      rem_q <= diff[dpr_pkg::DEG_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/dpr_dpath.sv =====
// Datapath: weight, degree and rank memories, shared multiplier, dividers.
module dpr_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dpr_pkg::CFG_W-1:0]       cfg_data_i,
  input  dpr_pkg::in_word_t               in_data_i,
  input  dpr_pkg::cmd_t                   cmd_i,
  output dpr_pkg::stat_t                  stat_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dpr_pkg::out_word_t              out_data_o
);

  localparam int unsigned RW = dpr_pkg::RANK_W;

  logic [dpr_pkg::WEIGHT_W-1:0] weight_mem [2**dpr_pkg::ADDR_W];
  logic [dpr_pkg::DEG_W-1:0]    deg_mem    [2**dpr_pkg::NODE_W];
  logic [RW-1:0]                rank_mem   [4][2**dpr_pkg::NODE_W];

  logic [dpr_pkg::DAMP_W-1:0]   damping_q;
  logic [dpr_pkg::WEIGHT_W-1:0] wrd_q;
  logic [dpr_pkg::DEG_W-1:0]    drd_q;
  logic [RW-1:0]                rrd_q  [4];
  logic [RW-1:0]                acc_q  [4];
  logic [RW-1:0]                dres_q [4];
  logic [RW-1:0]                wp_q   [2];
  logic [RW-1:0]                tele_n_q;
  logic [63:0]                  plo_q;
  logic [RW-1:0]                phi_q;
  dpr_pkg::out_word_t           out_q;
  logic                         out_valid_q;

  logic [16:0]                  one_minus_d;
  logic [RW-1:0]                tele;
  logic [RW-1:0]                mul_a;
  logic [dpr_pkg::WEIGHT_W-1:0] mul_b;
  logic [79:0]                  mul_full;
  logic [RW-1:0]                mul_res;
  logic [RW-1:0]                div_a [4];
  logic [dpr_pkg::DEG_W-1:0]    div_b;
  logic [RW-1:0]                quo   [4];
  logic [3:0]                   busy;
  logic                         div_start;
  logic [RW-1:0]                wr_data [4];
  logic                         out_load;

  assign one_minus_d = 17'(17'h10000 - {1'b0, damping_q});
  assign tele        = RW'({one_minus_d, 8'd0});

  // config: only damping lives here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q <= 16'd55706;
    end else if (cfg_we_i && cfg_idx_i == dpr_pkg::REG_DAMPING) begin
      damping_q <= cfg_data_i;
    end
  end

  // weight and degree stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dpr_pkg::CMD_CLEAR) begin
      weight_mem[cmd_i.clr_addr]                 <= '0;
      deg_mem[cmd_i.clr_addr[dpr_pkg::NODE_W-1:0]] <= '0;
    end else if (cmd_i.op == dpr_pkg::CMD_LOAD) begin
      if (in_data_i.mode == dpr_pkg::MODE_WEIGHT) begin
        weight_mem[{in_data_i.source_node, in_data_i.target_node}] <= in_data_i.link_weight;
      end else if (in_data_i.mode == dpr_pkg::MODE_DEGREE) begin
        deg_mem[in_data_i.source_node] <= in_data_i.out_degree;
      end
    end
    if (cmd_i.op == dpr_pkg::CMD_READ) begin
      wrd_q <= weight_mem[{cmd_i.col, cmd_i.row}];
      drd_q <= deg_mem[cmd_i.col];
    end
  end

  // rank stores, one per variant
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (cmd_i.op == dpr_pkg::CMD_INIT) begin
        wr_data[k] = dpr_pkg::RANK_ONE;
      end else begin
        wr_data[k] = dpr_pkg::sat_add((k == 0 || k == 3) ? tele_n_q : tele, dres_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (cmd_i.op == dpr_pkg::CMD_INIT || cmd_i.op == dpr_pkg::CMD_WRITE) begin
        rank_mem[k][cmd_i.row] <= wr_data[k];
      end
      if (cmd_i.op == dpr_pkg::CMD_READ) begin
        rrd_q[k] <= rank_mem[k][cmd_i.col];
      end
    end
  end

  // shared multiplier: low 32 bits, then high 16 bits, then combine
  always_comb begin
    mul_b = {{(dpr_pkg::WEIGHT_W-dpr_pkg::DAMP_W){1'b0}}, damping_q};
    unique case (cmd_i.mop)
      dpr_pkg::MOP_R3: begin mul_a = rrd_q[2]; mul_b = wrd_q; end
      dpr_pkg::MOP_R4: begin mul_a = rrd_q[3]; mul_b = wrd_q; end
      dpr_pkg::MOP_A1: mul_a = acc_q[0];
      dpr_pkg::MOP_A2: mul_a = acc_q[1];
      dpr_pkg::MOP_A3: mul_a = acc_q[2];
      dpr_pkg::MOP_A4: mul_a = acc_q[3];
      default:         mul_a = acc_q[0];
    endcase
  end

  assign mul_full = {phi_q, 32'd0} + {16'd0, plo_q};
  assign mul_res  = (|mul_full[79:64]) ? dpr_pkg::RMAX : mul_full[63:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dpr_pkg::CMD_MUL_LO) begin
      plo_q <= {32'd0, mul_a[31:0]} * {32'd0, mul_b};
    end
    if (cmd_i.op == dpr_pkg::CMD_MUL_HI) begin
      // 16 x 32 product, 48 bits wide
      phi_q <= {32'd0, mul_a[RW-1:32]} * {16'd0, mul_b};
    end
    if (cmd_i.op == dpr_pkg::CMD_MUL_CMB) begin
      unique case (cmd_i.mop)
        dpr_pkg::MOP_R3: wp_q[0]   <= mul_res;
        dpr_pkg::MOP_R4: wp_q[1]   <= mul_res;
        dpr_pkg::MOP_A1: dres_q[0] <= mul_res;
        dpr_pkg::MOP_A2: dres_q[1] <= mul_res;
        dpr_pkg::MOP_A3: dres_q[2] <= mul_res;
        dpr_pkg::MOP_A4: dres_q[3] <= mul_res;
        default: ;
      endcase
    end
  end

  // four dividers; lane 0 also forms the teleport share
  assign div_start = (cmd_i.op == dpr_pkg::CMD_DIV) || (cmd_i.op == dpr_pkg::CMD_TDIV);
  assign div_a[0]  = (cmd_i.op == dpr_pkg::CMD_TDIV) ? tele : rrd_q[0];
  assign div_a[1]  = rrd_q[1];
  assign div_a[2]  = wp_q[0];
  assign div_a[3]  = wp_q[1];
  assign div_b     = (cmd_i.op == dpr_pkg::CMD_TDIV) ? cmd_i.count : drd_q;

  for (genvar g = 0; g < 4; g++) begin : g_div
    dpr_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (div_a[g]),
      .divisor_i  (div_b),
      .busy_o     (busy[g]),
      .quotient_o (quo[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dpr_pkg::CMD_TSTORE) begin
      tele_n_q <= quo[0];
    end
    for (int k = 0; k < 4; k++) begin
      if (cmd_i.op == dpr_pkg::CMD_ACC_CLR) begin
        acc_q[k] <= '0;
      end else if (cmd_i.op == dpr_pkg::CMD_ACC) begin
        acc_q[k] <= dpr_pkg::sat_add(acc_q[k], quo[k]);
      end
    end
  end

  // output word register
  assign out_load = (cmd_i.op == dpr_pkg::CMD_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.node_index             <= cmd_i.col;
      out_q.rank_plain             <= rrd_q[0];
      out_q.rank_unscaled          <= rrd_q[1];
      out_q.rank_weighted_unscaled <= rrd_q[2];
      out_q.rank_weighted          <= rrd_q[3];
      out_q.last                   <= cmd_i.last;
    end
  end

  assign stat_o.skip     = (wrd_q == '0) || (drd_q == '0);
  assign stat_o.div_busy = |busy;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ===== src/dpr_ctrl.sv =====
// Controller: clear pass, load decode, sweep sequencing and emission.
module dpr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dpr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic [1:0]                    in_mode_i,
  output logic                          in_ready_o,
  input  dpr_pkg::stat_t                stat_i,
  output dpr_pkg::cmd_t                 cmd_o
);

  typedef enum logic [15:0] {
    ST_CLEAR = 16'h0001,
    ST_IDLE  = 16'h0002,
    ST_TDIV  = 16'h0004,
    ST_TWAIT = 16'h0008,
    ST_INIT  = 16'h0010,
    ST_NODE  = 16'h0020,
    ST_RD    = 16'h0040,
    ST_CHK   = 16'h0080,
    ST_ML    = 16'h0100,
    ST_MH    = 16'h0200,
    ST_MC    = 16'h0400,
    ST_DIV   = 16'h0800,
    ST_DIVW  = 16'h1000,
    ST_WR    = 16'h2000,
    ST_ERD   = 16'h4000,
    ST_EOUT  = 16'h8000
  } state_e;

  state_e                         state_q, state_d;
  logic [dpr_pkg::ADDR_W-1:0]     clr_q, clr_d;
  logic [dpr_pkg::NODE_W-1:0]     i_q, i_d, j_q, j_d;
  logic [dpr_pkg::ITER_W-1:0]     it_q, it_d;
  logic [dpr_pkg::CNT_W-1:0]      n_q, n_d;
  dpr_pkg::mop_e                  mop_q, mop_d;
  dpr_pkg::cmd_e                  cmd_op;
  logic [dpr_pkg::CNT_W-1:0]      node_count_q;
  logic [dpr_pkg::ITER_W-1:0]     iter_q;
  logic [dpr_pkg::CNT_W-1:0]      n_clamp;
  logic [dpr_pkg::CNT_W-1:0]      n_m1;
  logic                           last_i, last_j;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'd64;
      iter_q       <= 8'd100;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dpr_pkg::REG_NODE_COUNT) begin
        node_count_q <= cfg_data_i[dpr_pkg::CNT_W-1:0];
      end else if (cfg_idx_i == dpr_pkg::REG_ITER_COUNT) begin
        iter_q <= cfg_data_i[dpr_pkg::ITER_W-1:0];
      end
    end
  end

  assign n_clamp = (node_count_q == '0) ? 7'd1 :
                   (node_count_q > dpr_pkg::MAX_NODES_C) ? dpr_pkg::MAX_NODES_C : node_count_q;
  assign n_m1    = n_q - 7'd1;
  assign last_i  = ({1'b0, i_q} == n_m1);
  assign last_j  = ({1'b0, j_q} == n_m1);

  assign in_ready_o   = (state_q == ST_IDLE);
  assign cmd_o.op       = cmd_op;
  assign cmd_o.mop      = mop_q;
  assign cmd_o.row      = i_q;
  assign cmd_o.col      = j_q;
  assign cmd_o.clr_addr = clr_q;
  assign cmd_o.count    = n_q;
  assign cmd_o.last     = last_j;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    i_d       = i_q;
    j_d       = j_q;
    it_d      = it_q;
    n_d       = n_q;
    mop_d     = mop_q;
    cmd_op    = dpr_pkg::CMD_IDLE;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_op = dpr_pkg::CMD_CLEAR;
        clr_d  = clr_q + 1'b1;
        if (&clr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_mode_i == dpr_pkg::MODE_WEIGHT || in_mode_i == dpr_pkg::MODE_DEGREE) begin
            cmd_op = dpr_pkg::CMD_LOAD;
          end else if (in_mode_i == dpr_pkg::MODE_RUN) begin
            n_d     = n_clamp;
            state_d = ST_TDIV;
          end
        end
      end
      ST_TDIV: begin
        cmd_op  = dpr_pkg::CMD_TDIV;
        state_d = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_op  = dpr_pkg::CMD_TSTORE;
          i_d     = '0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_op = dpr_pkg::CMD_INIT;
        if (last_i) begin
          i_d  = '0;
          it_d = '0;
          j_d  = '0;
          state_d = (iter_q == '0) ? ST_ERD : ST_NODE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_NODE: begin
        cmd_op  = dpr_pkg::CMD_ACC_CLR;
        j_d     = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        cmd_op  = dpr_pkg::CMD_READ;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (stat_i.skip) begin
          if (last_j) begin
            mop_d = dpr_pkg::MOP_A1;
            state_d = ST_ML;
          end else begin
            j_d = j_q + 1'b1;
            state_d = ST_RD;
          end
        end else begin
          mop_d   = dpr_pkg::MOP_R3;
          state_d = ST_ML;
        end
      end
      ST_ML: begin
        cmd_op  = dpr_pkg::CMD_MUL_LO;
        state_d = ST_MH;
      end
      ST_MH: begin
        cmd_op  = dpr_pkg::CMD_MUL_HI;
        state_d = ST_MC;
      end
      ST_MC: begin
        cmd_op = dpr_pkg::CMD_MUL_CMB;
        unique case (mop_q)
          dpr_pkg::MOP_R3: begin mop_d = dpr_pkg::MOP_R4; state_d = ST_ML; end
          dpr_pkg::MOP_R4: state_d = ST_DIV;
          dpr_pkg::MOP_A1: begin mop_d = dpr_pkg::MOP_A2; state_d = ST_ML; end
          dpr_pkg::MOP_A2: begin mop_d = dpr_pkg::MOP_A3; state_d = ST_ML; end
          dpr_pkg::MOP_A3: begin mop_d = dpr_pkg::MOP_A4; state_d = ST_ML; end
          dpr_pkg::MOP_A4: state_d = ST_WR;
          default:         state_d = ST_WR;
        endcase
      end
      ST_DIV: begin
        cmd_op  = dpr_pkg::CMD_DIV;
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (!stat_i.div_busy) begin
          cmd_op = dpr_pkg::CMD_ACC;
          if (last_j) begin
            mop_d   = dpr_pkg::MOP_A1;
            state_d = ST_ML;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_WR: begin
        cmd_op = dpr_pkg::CMD_WRITE;
        if (last_i) begin
          i_d = '0;
          if (it_q == iter_q - 8'd1) begin
            j_d     = '0;
            state_d = ST_ERD;
          end else begin
            it_d    = it_q + 1'b1;
            state_d = ST_NODE;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_NODE;
        end
      end
      ST_ERD: begin
        cmd_op  = dpr_pkg::CMD_READ;
        state_d = ST_EOUT;
      end
      ST_EOUT: begin
        if (stat_i.out_free) begin
          cmd_op = dpr_pkg::CMD_EMIT;
          if (last_j) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_ERD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      it_q    <= '0;
      n_q     <= 7'd1;
      mop_q   <= dpr_pkg::MOP_R3;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      i_q     <= i_d;
      j_q     <= j_d;
      it_q    <= it_d;
      n_q     <= n_d;
      mop_q   <= mop_d;
    end
  end

`ifndef ASSERT_OFF
  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> stat_i.div_busy)
    else $error("divider not busy after start");
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD || state_q == ST_ERD) |-> ({1'b0, j_q} < n_q))
    else $error("column index beyond node count");
  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR || state_q == ST_INIT) |-> ({1'b0, i_q} < n_q))
    else $error("row index beyond node count");
`endif

endmodule

// ===== src/dense_pagerank_four_variant.sv =====
// Top level of the dense four-variant PageRank block.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_ready_o   | dpr_pkg::in_word_t
//  out     | output    | out_valid_o / out_ready_i | dpr_pkg::out_word_t
//  cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// Load words (weight or degree write) are taken in idle, which they do not leave.
// A run word is followed by a teleport divide, rank initialisation, the sweeps
// over (node, source) and emission; sources without an edge into a node are
// skipped, and the bit-serial divide dominates each edge. Emission waits
// whenever the output stalls. After reset a clearing pass over the weight and
// degree stores runs before the first input word is taken; cfg writes are
// taken throughout.
module dense_pagerank_four_variant (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dpr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dpr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dpr_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dpr_pkg::out_word_t            out_data_o
);

  dpr_pkg::cmd_t  cmd;   // controller -> datapath
  dpr_pkg::stat_t stat;  // datapath -> controller

  // sequencing: clear pass, sweeps over (iteration, node, source), emission
  dpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stores, multiplier, dividers and the output word register
  dpr_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/dense_pagerank_four_variant_test.sv =====
// Self-checking testbench of the dense four-variant PageRank block.
module dense_pagerank_four_variant_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 of the cfg port holds no register; writes there must be dropped.
  localparam logic [dpr_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam logic [1:0] MODE_NOP = 2'd3;
  // A run may block the input for a long time; this bounds a silent stretch.
  localparam int unsigned SILENT_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 64;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [dpr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [dpr_pkg::CFG_W-1:0]     cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  dpr_pkg::in_word_t             in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  dpr_pkg::out_word_t            out_data_o;

  dense_pagerank_four_variant dut (.*);

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Shadow copy of the block's state.
  logic [dpr_pkg::WEIGHT_W-1:0] edge_w [64][64];
  logic [dpr_pkg::DEG_W-1:0]    out_deg [64];
  logic [dpr_pkg::RANK_W-1:0]   r_plain [64];
  logic [dpr_pkg::RANK_W-1:0]   r_unsc [64];
  logic [dpr_pkg::RANK_W-1:0]   r_wunsc [64];
  logic [dpr_pkg::RANK_W-1:0]   r_wgt [64];
  logic [dpr_pkg::CNT_W-1:0]    nodes_cfg;
  logic [dpr_pkg::ITER_W-1:0]   sweeps_cfg;
  logic [dpr_pkg::DAMP_W-1:0]   damp_cfg;

  dpr_pkg::in_word_t  pending_words [$];
  dpr_pkg::out_word_t rank_queue [$];
  int unsigned errors;
  int unsigned runs_done;
  int unsigned ranks_checked;
  int unsigned silent_cycles;
  logic        calm;  // no idling on either side while set

  function automatic logic [dpr_pkg::RANK_W-1:0] clamp_add(
      input logic [dpr_pkg::RANK_W-1:0] a, input logic [dpr_pkg::RANK_W-1:0] b);
    logic [dpr_pkg::RANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[dpr_pkg::RANK_W] ? dpr_pkg::RMAX : s[dpr_pkg::RANK_W-1:0];
  endfunction

  // floor(a * b / 2^16), clamped to the rank range
  function automatic logic [dpr_pkg::RANK_W-1:0] q16_scale(
      input logic [dpr_pkg::RANK_W-1:0] a, input logic [31:0] b);
    logic [79:0] p;
    p = {32'd0, a} * {48'd0, b};
    p = p >> 16;
    return (p[79:48] != 0) ? dpr_pkg::RMAX : p[47:0];
  endfunction

  function automatic int unsigned pick_delay();
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Gauss-Seidel sweeps, then one expected word per node.
  task automatic predict_ranks();
    int n;
    logic [dpr_pkg::RANK_W-1:0] tele, tele_n, a1, a2, a3, a4;
    logic [dpr_pkg::DEG_W-1:0] dg;
    dpr_pkg::out_word_t w;
    n = (nodes_cfg == 0) ? 1 : (nodes_cfg > 64) ? 64 : int'(nodes_cfg);
    tele = (48'd65536 - {32'd0, damp_cfg}) << 8;
    tele_n = tele / n;
    for (int i = 0; i < n; i++) begin
      r_plain[i] = dpr_pkg::RANK_ONE;
      r_unsc[i]  = dpr_pkg::RANK_ONE;
      r_wunsc[i] = dpr_pkg::RANK_ONE;
      r_wgt[i]   = dpr_pkg::RANK_ONE;
    end
    for (int it = 0; it < int'(sweeps_cfg); it++) begin
      for (int i = 0; i < n; i++) begin
        a1 = '0; a2 = '0; a3 = '0; a4 = '0;
        for (int j = 0; j < n; j++) begin
          dg = out_deg[j];
          if (edge_w[j][i] != 0 && dg != 0) begin
            a1 = clamp_add(a1, r_plain[j] / dg);
            a2 = clamp_add(a2, r_unsc[j] / dg);
            a3 = clamp_add(a3, q16_scale(r_wunsc[j], edge_w[j][i]) / dg);
            a4 = clamp_add(a4, q16_scale(r_wgt[j], edge_w[j][i]) / dg);
          end
        end
        r_plain[i] = clamp_add(tele_n, q16_scale(a1, {16'd0, damp_cfg}));
        r_unsc[i]  = clamp_add(tele,   q16_scale(a2, {16'd0, damp_cfg}));
        r_wunsc[i] = clamp_add(tele,   q16_scale(a3, {16'd0, damp_cfg}));
        r_wgt[i]   = clamp_add(tele_n, q16_scale(a4, {16'd0, damp_cfg}));
      end
    end
    for (int i = 0; i < n; i++) begin
      w.node_index = i[dpr_pkg::NODE_W-1:0];
      w.rank_plain = r_plain[i];
      w.rank_unscaled = r_unsc[i];
      w.rank_weighted_unscaled = r_wunsc[i];
      w.rank_weighted = r_wgt[i];
      w.last = (i == n - 1);
      rank_queue.push_back(w);
    end
    runs_done++;
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [dpr_pkg::RANK_W-1:0] got,
                                 input logic [dpr_pkg::RANK_W-1:0] want);
    errors++;
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Input driver: one word per slot, random gap after each word.
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_gap != 0) begin
        in_gap     <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        in_data_i  <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        in_gap     <= pick_delay();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Accepted input words update the shadow state; a run queues its ranks.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      case (in_data_i.mode)
        dpr_pkg::MODE_WEIGHT: begin
          edge_w[in_data_i.source_node][in_data_i.target_node] = in_data_i.link_weight;
        end
        dpr_pkg::MODE_DEGREE: begin
          out_deg[in_data_i.source_node] = in_data_i.out_degree;
        end
        dpr_pkg::MODE_RUN: begin
          predict_ranks();
        end
        default: ;
      endcase
    end
  end

  // Output side: random stall after each word, compare against oldest expectation.
  int unsigned out_stall;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall   <= 0;
    end else if (out_stall != 0) begin
      out_stall   <= out_stall - 1;
      out_ready_i <= (out_stall == 1);
    end else if (out_valid_o && out_ready_i) begin
      out_stall   <= pick_delay();
      out_ready_i <= (pick_delay() == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dpr_pkg::out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rank_queue.size() == 0) begin
        report_mismatch("unexpected word, node", out_data_o.node_index, '0);
      end else begin
        want = rank_queue.pop_front();
        ranks_checked++;
        if (out_data_o.node_index != want.node_index)
          report_mismatch("node_index", out_data_o.node_index, want.node_index);
        if (out_data_o.rank_plain != want.rank_plain)
          report_mismatch("rank_plain", out_data_o.rank_plain, want.rank_plain);
        if (out_data_o.rank_unscaled != want.rank_unscaled)
          report_mismatch("rank_unscaled", out_data_o.rank_unscaled, want.rank_unscaled);
        if (out_data_o.rank_weighted_unscaled != want.rank_weighted_unscaled)
          report_mismatch("rank_weighted_unscaled", out_data_o.rank_weighted_unscaled,
                          want.rank_weighted_unscaled);
        if (out_data_o.rank_weighted != want.rank_weighted)
          report_mismatch("rank_weighted", out_data_o.rank_weighted, want.rank_weighted);
        if (out_data_o.last != want.last)
          report_mismatch("last", out_data_o.last, want.last);
      end
    end
  end

  // Watchdog: too long without a word moving on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      silent_cycles <= 0;
    end else if (silent_cycles >= SILENT_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      silent_cycles <= silent_cycles + 1;
    end
  end

  function automatic dpr_pkg::in_word_t make_word(input logic [1:0] mode, input int src,
                                                  input int tgt, input logic [31:0] wt,
                                                  input int deg);
    dpr_pkg::in_word_t w;
    w.mode = mode;
    w.source_node = src[dpr_pkg::NODE_W-1:0];
    w.target_node = tgt[dpr_pkg::NODE_W-1:0];
    w.link_weight = wt;
    w.out_degree = deg[dpr_pkg::DEG_W-1:0];
    return w;
  endfunction

  // Register write; the shadow copy follows at once since the block is idle.
  task automatic write_reg(input logic [dpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dpr_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      dpr_pkg::REG_NODE_COUNT: nodes_cfg = val[dpr_pkg::CNT_W-1:0];
      dpr_pkg::REG_ITER_COUNT: sweeps_cfg = val[dpr_pkg::ITER_W-1:0];
      dpr_pkg::REG_DAMPING:    damp_cfg = val[dpr_pkg::DAMP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(input int n, input int it, input int d);
    write_reg(dpr_pkg::REG_NODE_COUNT, n[dpr_pkg::CFG_W-1:0]);
    write_reg(dpr_pkg::REG_ITER_COUNT, it[dpr_pkg::CFG_W-1:0]);
    write_reg(dpr_pkg::REG_DAMPING, d[dpr_pkg::CFG_W-1:0]);
  endtask

  // Everything sent and checked, sampled at clock edges, plus time for a load
  // word still in work.
  task automatic drain();
    wait (pending_words.size() == 0);
    do begin
      @(posedge clk_i);
    end while (in_valid_i || rank_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic dpr_pkg::in_word_t random_load();
    int sel, src, tgt, deg;
    logic [31:0] wt;
    sel = $urandom_range(0, 99);
    src = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    tgt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    case ($urandom_range(0, 5))
      0: wt = 32'd0;
      1: wt = 32'hFFFF_FFFF;
      2: wt = $urandom_range(32'h8000, 32'h2_0000);
      default: wt = $urandom;
    endcase
    deg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 8);
    if (sel < 50) return make_word(dpr_pkg::MODE_WEIGHT, src, tgt, wt, deg);
    if (sel < 94) return make_word(dpr_pkg::MODE_DEGREE, src, tgt, wt, deg);
    return make_word(MODE_NOP, src, tgt, wt, deg);
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    errors = 0;
    runs_done = 0;
    ranks_checked = 0;
    calm = 1'b0;
    for (int i = 0; i < 64; i++) begin
      out_deg[i] = '0;
      for (int j = 0; j < 64; j++) edge_w[i][j] = '0;
    end
    nodes_cfg = 7'd64;
    sweeps_cfg = 8'd100;
    damp_cfg = 16'd55706;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Small graph: unit and maximal weights, a zero-degree source, a wide
    // degree, an ignored mode, and a write to the unused register index.
    set_regs(3, 1, 55706);
    write_reg(REG_NONE, 16'hFFFF);
    pending_words.push_back(make_word(dpr_pkg::MODE_WEIGHT, 0, 1, 32'h0001_0000, 0));
    pending_words.push_back(make_word(dpr_pkg::MODE_WEIGHT, 1, 0, 32'hFFFF_FFFF, 0));
    pending_words.push_back(make_word(dpr_pkg::MODE_WEIGHT, 2, 0, 32'h0000_0001, 0));
    pending_words.push_back(make_word(dpr_pkg::MODE_WEIGHT, 1, 2, 32'h0003_8000, 0));
    pending_words.push_back(make_word(dpr_pkg::MODE_DEGREE, 0, 63, 32'hFFFF_FFFF, 1));
    pending_words.push_back(make_word(dpr_pkg::MODE_DEGREE, 1, 0, 0, 64));
    pending_words.push_back(make_word(dpr_pkg::MODE_DEGREE, 2, 0, 0, 0));
    pending_words.push_back(make_word(dpr_pkg::MODE_DEGREE, 63, 0, 0, 127));
    pending_words.push_back(make_word(dpr_pkg::MODE_WEIGHT, 63, 63, 32'hFFFF_FFFF, 127));
    pending_words.push_back(make_word(MODE_NOP, 63, 63, 32'hFFFF_FFFF, 127));
    pending_words.push_back(make_word(dpr_pkg::MODE_RUN, 0, 0, 0, 0));
    drain();
    // Zero node count acts as one node, zero sweeps leaves every rank at 1.0.
    set_regs(0, 0, 0);
    pending_words.push_back(make_word(dpr_pkg::MODE_RUN, 63, 63, 32'hFFFF_FFFF, 127));
    drain();
    // Node count above the limit clamps to 64; full damping.
    set_regs(127, 1, 65535);
    pending_words.push_back(make_word(dpr_pkg::MODE_RUN, 0, 0, 0, 0));
    drain();
    // Longest sweep count on a two-node loop.
    set_regs(2, 255, 32768);
    pending_words.push_back(make_word(dpr_pkg::MODE_WEIGHT, 0, 1, 32'h0002_0000, 0));
    pending_words.push_back(make_word(dpr_pkg::MODE_RUN, 0, 0, 0, 0));
    drain();
    // Exactly 64 nodes, damping zero.
    set_regs(64, 1, 0);
    pending_words.push_back(make_word(dpr_pkg::MODE_RUN, 0, 0, 0, 0));
    drain();

    // Random phases: fresh registers, a batch of loads, then one run.
    for (int ph = 0; ph < 18; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      set_regs($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(0, 65535));
      repeat ($urandom_range(12, 22)) pending_words.push_back(random_load());
      pending_words.push_back(make_word(dpr_pkg::MODE_RUN, $urandom_range(0, 63),
                                        $urandom_range(0, 63), $urandom,
                                        $urandom_range(0, 127)));
      drain();
    end

    $display("Covered %0d runs with %0d rank words checked, %0d errors.",
             runs_done, ranks_checked, errors);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== dense_pagerank_four_variant.f =====
src/dpr_pkg.sv
src/dpr_div.sv
src/dpr_dpath.sv
src/dpr_ctrl.sv
src/dense_pagerank_four_variant.sv
dv/dense_pagerank_four_variant_test.sv
